### rtl/epsilon_greedy_action_select_assert.svh
// Assertion macros for the epsilon-greedy action select block.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef EPSILON_GREEDY_ACTION_SELECT_ASSERT_SVH
`define EPSILON_GREEDY_ACTION_SELECT_ASSERT_SVH

// same-cycle implication
`define EGAS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("egas: same-cycle check failed");

// next-cycle implication
`define EGAS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("egas: next-cycle check failed");

`endif

### rtl/egas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egas_pkg
// Types and constants of the epsilon-greedy action select block.
// ----------------------------------------------------------------------------
package egas_pkg;

	localparam int ACTION_SLOTS = 64;
	localparam int POS_W       = $clog2(ACTION_SLOTS + 1);
	localparam int IDX_W       = $clog2(ACTION_SLOTS);
	localparam int CNT_W       = $clog2(ACTION_SLOTS + 1);

	localparam int Q_W      = 32;
	localparam int EPS_W    = 16;
	localparam int MARGIN_W = 17;
	localparam int DRAW_W   = 16;
	localparam int PROB_W   = 17;

	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 24;
	localparam int CFG_W    = 17;
	localparam int CFG_IDX_W = 1;

	// shared divider: 17-bit dividend, count-wide divisor
	localparam int DIV_W     = 17;
	localparam int DIV_STEPS = DIV_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIE_MARGIN = 1'b1;

	localparam logic [EPS_W-1:0]    EPSILON_RST    = 16'd6554;
	localparam logic [MARGIN_W-1:0] TIE_MARGIN_RST = 17'd1;
	localparam logic [PROB_W-1:0]   PROB_ONE       = 17'd65536;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		OP_RANK   = 2'd0,
		OP_EXPL   = 2'd1,
		OP_GREEDY = 2'd2
	} div_op_t;

endpackage

### rtl/epsilon_greedy_action_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epsilon_greedy_action_select
// Tracks best / allowed / tied actions over a set and picks one per set.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  s_axis   | in  | one action per beat; tlast closes the set
//  m_axis   | out | one decision per set
//  cfg      | in  | epsilon (0), tie_margin (1); write-only
//
//  Non-last beats are taken one per cycle while idle; tready stays high in idle.
//  A last beat is followed by a check state, three passes of the shared
//  restoring divider (17 steps each), a one-bit-per-cycle rank scan of up
//  to 64 slots and an output state; with nothing allowed, only check and output.
//  The result sits in an output register; a stalled m_axis holds the block
//  in its final state, while no beat of the next set is taken.
//  Reset clears the set state and loads epsilon 6554, tie_margin 1.
// ----------------------------------------------------------------------------
module epsilon_greedy_action_select (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// q_value[31:0], explore_draw[47:32], pick_draw[63:48], query_action[69:64]
	input  logic [egas_pkg::S_DATA_W-1:0]     s_axis_tdata,
	// allowed
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// chosen_action[5:0], explored[6], query_prob[23:7]
	output logic [egas_pkg::M_DATA_W-1:0]     m_axis_tdata,
	// no_choice
	output logic                              m_axis_tuser,
	input  logic                              cfg_we,
	input  logic [egas_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [egas_pkg::CFG_W-1:0]        cfg_data
);
	import egas_pkg::*;

	state_t                  state_q;
	div_op_t                 op_q;
	logic [EPS_W-1:0]        epsilon_q;
	logic [MARGIN_W-1:0]     tie_margin_q;

	logic signed [Q_W-1:0]   best_q;
	logic [ACTION_SLOTS-1:0] allowed_mask_q;
	logic [ACTION_SLOTS-1:0] tie_mask_q;
	logic [CNT_W-1:0]        allowed_cnt_q;
	logic [CNT_W-1:0]        tie_cnt_q;
	logic [POS_W-1:0]        pos_q;

	logic                    explore_q;
	logic [DRAW_W-1:0]       pick_q;
	logic [IDX_W-1:0]        query_q;

	logic [DIV_W-1:0]        dvd_q;
	logic [CNT_W-1:0]        dvs_q;
	logic [CNT_W-1:0]        rem_q;
	logic [STEP_W-1:0]       step_q;

	logic [IDX_W-1:0]        rank_q;
	logic [PROB_W-1:0]       prob_expl_q;
	logic [PROB_W-1:0]       prob_grd_q;
	logic [IDX_W-1:0]        scan_q;
	logic [IDX_W-1:0]        chosen_q;
	logic                    no_choice_q;

	logic                    out_valid_q;
	logic [M_DATA_W-1:0]     out_data_q;
	logic                    out_user_q;

	// input fields
	logic signed [Q_W-1:0]   in_q;
	logic [DRAW_W-1:0]       in_explore;
	logic [DRAW_W-1:0]       in_pick;
	logic [IDX_W-1:0]        in_query;
	logic                    s_beat;
	logic                    in_range;
	logic [IDX_W-1:0]        pos_idx;
	logic signed [Q_W:0]     diff;
	logic                    take_best;
	logic                    take_tie;

	assign in_q       = s_axis_tdata[Q_W-1:0];
	assign in_explore = s_axis_tdata[Q_W+DRAW_W-1:Q_W];
	assign in_pick    = s_axis_tdata[Q_W+2*DRAW_W-1:Q_W+DRAW_W];
	assign in_query   = s_axis_tdata[Q_W+2*DRAW_W+IDX_W-1:Q_W+2*DRAW_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_beat        = s_axis_tvalid && s_axis_tready;
	assign in_range      = (pos_q < POS_W'(ACTION_SLOTS));
	assign pos_idx       = pos_q[IDX_W-1:0];

	// best - q, only looked at when q <= best
	assign diff      = {best_q[Q_W-1], best_q} - {in_q[Q_W-1], in_q};
	assign take_best = (allowed_cnt_q == '0) || (in_q > best_q);
	assign take_tie  = (diff[Q_W-1:0] < {{(Q_W-MARGIN_W){1'b0}}, tie_margin_q});

	// shared divider datapath
	logic [CNT_W:0]          rem_sh;
	logic                    div_ge;
	logic [CNT_W:0]          rem_sub;
	logic [CNT_W-1:0]        rem_nx;
	logic [DIV_W-1:0]        quot_nx;
	logic                    div_last;

	assign rem_sh   = {rem_q, dvd_q[DIV_W-1]};
	assign div_ge   = (rem_sh >= {1'b0, dvs_q});
	assign rem_sub  = rem_sh - {1'b0, dvs_q};
	assign rem_nx   = div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
	assign quot_nx  = {dvd_q[DIV_W-2:0], div_ge};
	assign div_last = (step_q == STEP_W'(DIV_STEPS - 1));

	logic [ACTION_SLOTS-1:0] scan_mask;
	logic                    scan_hit;
	logic [PROB_W:0]         prob_sum;
	logic                    out_free;

	assign scan_mask = explore_q ? allowed_mask_q : tie_mask_q;
	assign scan_hit  = scan_mask[scan_q];
	assign prob_sum  = {1'b0, prob_expl_q} +
		(tie_mask_q[query_q] ? {1'b0, prob_grd_q} : '0);
	assign out_free  = !out_valid_q || m_axis_tready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q    <= EPSILON_RST;
			tie_margin_q <= TIE_MARGIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EPSILON:    epsilon_q    <= cfg_data[EPS_W-1:0];
				REG_TIE_MARGIN: tie_margin_q <= cfg_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// set state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_q           <= OP_RANK;
			best_q         <= {1'b1, {(Q_W-1){1'b0}}};
			allowed_mask_q <= '0;
			tie_mask_q     <= '0;
			allowed_cnt_q  <= '0;
			tie_cnt_q      <= '0;
			pos_q          <= '0;
			step_q         <= '0;
			scan_q         <= '0;
			no_choice_q    <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_beat) begin
						if (in_range) begin
							if (s_axis_tuser) begin
								allowed_mask_q[pos_idx] <= 1'b1;
								if (take_best) begin
									best_q     <= in_q;
									tie_mask_q <= ACTION_SLOTS'(1) << pos_idx;
									tie_cnt_q  <= CNT_W'(1);
								end else if (take_tie) begin
									tie_mask_q[pos_idx] <= 1'b1;
									tie_cnt_q           <= tie_cnt_q + 1'b1;
								end
								allowed_cnt_q <= allowed_cnt_q + 1'b1;
							end
							pos_q <= pos_q + 1'b1;
						end
						if (s_axis_tlast)
							state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					step_q <= '0;
					op_q   <= OP_RANK;
					if (allowed_cnt_q == '0) begin
						no_choice_q <= 1'b1;
						state_q     <= ST_OUT;
					end else begin
						no_choice_q <= 1'b0;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= div_last ? '0 : step_q + 1'b1;
					if (div_last) begin
						case (op_q)
							OP_RANK:   op_q <= OP_EXPL;
							OP_EXPL:   op_q <= OP_GREEDY;
							OP_GREEDY: begin
								scan_q  <= '0;
								state_q <= ST_SCAN;
							end
							default:   op_q <= OP_RANK;
						endcase
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if ((scan_hit && rank_q == '0) || scan_q == IDX_W'(ACTION_SLOTS - 1))
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						best_q         <= {1'b1, {(Q_W-1){1'b0}}};
						allowed_mask_q <= '0;
						tie_mask_q     <= '0;
						allowed_cnt_q  <= '0;
						tie_cnt_q      <= '0;
						pos_q          <= '0;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_beat && s_axis_tlast) begin
					explore_q <= (in_explore < epsilon_q);
					pick_q    <= in_pick;
					query_q   <= in_query;
				end
			end
			ST_CHECK: begin
				// first pass: pick_draw mod candidate count
				dvd_q <= {1'b0, pick_q};
				dvs_q <= explore_q ? allowed_cnt_q : tie_cnt_q;
				rem_q <= '0;
			end
			ST_DIV: begin
				if (div_last) begin
					case (op_q)
						OP_RANK: begin
							rank_q <= rem_nx[IDX_W-1:0];
							dvd_q  <= {1'b0, epsilon_q};
							dvs_q  <= allowed_cnt_q;
						end
						OP_EXPL: begin
							prob_expl_q <= quot_nx;
							dvd_q       <= PROB_ONE - {1'b0, epsilon_q};
							dvs_q       <= tie_cnt_q;
						end
						OP_GREEDY: prob_grd_q <= quot_nx;
						default: ;
					endcase
					rem_q <= '0;
				end else begin
					dvd_q <= quot_nx;
					rem_q <= rem_nx;
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					if (rank_q == '0)
						chosen_q <= scan_q;
					else
						rank_q <= rank_q - 1'b1;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					if (no_choice_q)
						out_data_q <= '0;
					else
						out_data_q <= {prob_sum[PROB_W-1:0], explore_q, chosen_q};
					out_user_q <= no_choice_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

`include "epsilon_greedy_action_select_assert.svh"

	`EGAS_ASSERT_IMP(a_tie_le_allowed, 1'b1, tie_cnt_q <= allowed_cnt_q)
	`EGAS_ASSERT_IMP(a_tie_cnt_match, 1'b1, $countones(tie_mask_q) == int'(tie_cnt_q))
	`EGAS_ASSERT_IMP(a_allow_cnt_match, 1'b1, $countones(allowed_mask_q) == int'(allowed_cnt_q))
	`EGAS_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV, dvs_q != '0)
	`EGAS_ASSERT_NXT(a_out_clears_set, state_q == ST_OUT && out_free, allowed_cnt_q == '0 && pos_q == '0)

endmodule

### tb/epsilon_greedy_action_select_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epsilon_greedy_action_select_tb
// Streams action sets into the selector and checks every decision beat
// against an in-bench predictor that tracks allowed and tied-best actions.
// A directed section covers field extremes and corner cases. Random sets
// follow under several epsilon / tie margin settings, with random gaps on
// both streams in all but the last phase.
// ----------------------------------------------------------------------------
module epsilon_greedy_action_select_tb;
	import egas_pkg::*;

	localparam int DRAIN_CYCLES    = 130;
	localparam int QUIET_LIMIT     = 4000;
	localparam int ITEMS_PER_PHASE = 200;

	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic signed [Q_W-1:0] q_value;
		logic                  allowed;
		logic                  last_flag;
		logic [DRAW_W-1:0]     explore_draw;
		logic [DRAW_W-1:0]     pick_draw;
		logic [IDX_W-1:0]      query_action;
	} act_beat_t;

	typedef struct packed {
		logic [IDX_W-1:0]  chosen;
		logic              explored;
		logic [PROB_W-1:0] prob;
		logic              no_choice;
	} decision_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  s_axis_tlast  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = REG_EPSILON;
	logic [CFG_W-1:0]      cfg_data      = '0;

	// predictor copy of the registers and of the open set
	logic [EPS_W-1:0]        cur_epsilon;
	logic [MARGIN_W-1:0]     cur_margin;
	logic signed [Q_W-1:0]   lead_value;
	logic [ACTION_SLOTS-1:0] permit_mask;
	logic [ACTION_SLOTS-1:0] lead_mask;
	int unsigned             permit_cnt;
	int unsigned             lead_cnt;
	int unsigned             slot;

	decision_t   decisions_due[$];
	int          mismatches = 0;
	bit          gaps_on    = 1'b1;
	int unsigned rx_stall   = 0;
	int unsigned quiet      = 0;

	always #2 clk = ~clk;

	epsilon_greedy_action_select i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	function automatic void open_new_set();
		lead_value  = Q_MIN;
		permit_mask = '0;
		lead_mask   = '0;
		permit_cnt  = 0;
		lead_cnt    = 0;
		slot        = 0;
	endfunction

	// index of the set bit of the given rank
	function automatic logic [IDX_W-1:0] rank_to_index(input logic [ACTION_SLOTS-1:0] mask,
			input int unsigned rank);
		int unsigned left;
		left = rank;
		for (int i = 0; i < ACTION_SLOTS; i++) begin
			if (mask[i]) begin
				if (left == 0)
					return i[IDX_W-1:0];
				left--;
			end
		end
		return '0;
	endfunction

	function automatic void predict_decision(input act_beat_t a);
		logic [ACTION_SLOTS-1:0] bit_at;
		decision_t               d;
		int unsigned             share;
		if (slot < ACTION_SLOTS) begin
			if (a.allowed) begin
				bit_at = '0;
				bit_at[slot] = 1'b1;
				permit_mask |= bit_at;
				if (permit_cnt == 0 || $signed(a.q_value) > lead_value) begin
					// a strictly larger value restarts the tie set
					lead_value = a.q_value;
					lead_mask  = bit_at;
					lead_cnt   = 1;
				end else if (longint'(lead_value) - longint'($signed(a.q_value))
						< longint'(cur_margin)) begin
					lead_mask |= bit_at;
					lead_cnt++;
				end
				permit_cnt++;
			end
			slot++;
		end
		if (!a.last_flag)
			return;
		d = '0;
		if (permit_cnt == 0) begin
			d.no_choice = 1'b1;
		end else begin
			d.explored = a.explore_draw < cur_epsilon;
			if (d.explored)
				d.chosen = rank_to_index(permit_mask, a.pick_draw % permit_cnt);
			else
				d.chosen = rank_to_index(lead_mask, a.pick_draw % lead_cnt);
			share = cur_epsilon / permit_cnt;
			if (lead_mask[a.query_action])
				share += (PROB_ONE - cur_epsilon) / lead_cnt;
			d.prob = share[PROB_W-1:0];
		end
		decisions_due.insert(decisions_due.size(), d);
		open_new_set();
	endfunction

	function automatic act_beat_t act(input logic signed [Q_W-1:0] q, input logic allowed,
			input logic last_flag, input logic [DRAW_W-1:0] explore_draw,
			input logic [DRAW_W-1:0] pick_draw, input logic [IDX_W-1:0] query_action);
		act_beat_t a;
		a.q_value      = q;
		a.allowed      = allowed;
		a.last_flag    = last_flag;
		a.explore_draw = explore_draw;
		a.pick_draw    = pick_draw;
		a.query_action = query_action;
		return a;
	endfunction

	task automatic send_action(input act_beat_t a);
		int unsigned gap;
		gap = (gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
		if (gap != 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, a.query_action, a.pick_draw, a.explore_draw, a.q_value};
		s_axis_tuser  <= a.allowed;
		s_axis_tlast  <= a.last_flag;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		predict_decision(a);
	endtask

	// stop sending and let every outstanding decision come back
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (decisions_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [EPS_W-1:0] eps, input logic [MARGIN_W-1:0] margin);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_EPSILON;
		cfg_data  <= {1'b0, eps};
		@(negedge clk);
		cfg_index <= REG_TIE_MARGIN;
		cfg_data  <= margin;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_epsilon = eps;
		cur_margin  = margin;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// reset values: single action at the most negative value, then a set with
	// nothing allowed
	task automatic test_reset_defaults();
		send_action(act(Q_MIN, 1'b1, 1'b1, 16'd0, 16'hFFFF, 6'd0));
		send_action(act(-32'sd1, 1'b0, 1'b0, 16'hFFFF, 16'h0000, 6'd63));
		send_action(act(32'sd0, 1'b0, 1'b0, 16'h1234, 16'h5678, 6'd21));
		send_action(act(Q_MAX, 1'b0, 1'b1, 16'h5555, 16'hAAAA, 6'd63));
	endtask

	// a larger value within the margin restarts the ties; lower ones join
	task automatic test_tie_tracking();
		drain();
		set_config(EPSILON_RST, 17'd100);
		send_action(act(32'sd100, 1'b1, 1'b0, 16'd0, 16'd0, 6'd0));
		send_action(act(32'sd150, 1'b1, 1'b0, 16'd0, 16'd0, 6'd0));
		send_action(act(32'sd60, 1'b1, 1'b0, 16'd0, 16'd0, 6'd0));
		send_action(act(32'sd50, 1'b1, 1'b0, 16'd0, 16'd0, 6'd0));
		send_action(act(Q_MAX, 1'b0, 1'b0, 16'd0, 16'd0, 6'd0));
		send_action(act(32'sd149, 1'b1, 1'b1, 16'hFFFF, 16'd1, 6'd2));
	endtask

	task automatic test_zero_margin();
		drain();
		set_config(EPSILON_RST, 17'd0);
		send_action(act(32'sd7, 1'b1, 1'b0, 16'd0, 16'd0, 6'd0));
		send_action(act(32'sd7, 1'b1, 1'b0, 16'd0, 16'd0, 6'd0));
		send_action(act(32'sd7, 1'b1, 1'b1, 16'hFFFF, 16'd3, 6'd1));
	endtask

	// explore just below the largest epsilon, greedy at it, never at zero
	task automatic test_epsilon_extremes();
		drain();
		set_config(16'hFFFF, 17'h10000);
		send_action(act(Q_MIN, 1'b1, 1'b0, 16'd0, 16'd0, 6'd0));
		send_action(act(Q_MAX, 1'b1, 1'b0, 16'd0, 16'd0, 6'd0));
		send_action(act(32'sh7FFF_0000, 1'b1, 1'b1, 16'hFFFE, 16'hFFFF, 6'd63));
		send_action(act(32'sd5, 1'b1, 1'b0, 16'd0, 16'd0, 6'd0));
		send_action(act(32'sd5 - 32'sh10000, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 6'd1));
		drain();
		set_config(16'd0, TIE_MARGIN_RST);
		send_action(act(32'sd0, 1'b1, 1'b1, 16'd0, 16'd0, 6'd0));
	endtask

	task automatic test_random_sets(input logic [EPS_W-1:0] eps,
			input logic [MARGIN_W-1:0] margin, input int unsigned items);
		int unsigned           sent;
		int unsigned           len;
		int unsigned           mode;
		int unsigned           permit_pct;
		int unsigned           spread;
		logic signed [Q_W-1:0] base;
		act_beat_t             a;
		drain();
		set_config(eps, margin);
		sent = 0;
		while (sent < items) begin
			// mostly short sets, now and then a long one of 60 to 72 beats that may run past ACTION_SLOTS
			len        = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 72)
				: $urandom_range(1, 10);
			mode       = $urandom_range(0, 3);
			permit_pct = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(40, 100);
			base       = $signed($urandom()) >>> 2;
			for (int k = 0; k < len; k++) begin
				case (mode)
					0: a.q_value = $urandom();
					1: begin
						spread    = $urandom_range(0, 2 * cur_margin + 2);
						a.q_value = base - spread;
					end
					2: a.q_value = base + $urandom_range(0, 2) * 1000;
					default: begin
						case ($urandom_range(0, 3))
							0: a.q_value = Q_MIN;
							1: a.q_value = Q_MAX;
							2: a.q_value = '0;
							default: a.q_value = '1;
						endcase
					end
				endcase
				a.allowed   = $urandom_range(1, 100) <= permit_pct;
				a.last_flag = (k == len - 1);
				a.pick_draw = 16'($urandom());
				if (a.last_flag) begin
					case ($urandom_range(0, 4))
						0: a.explore_draw = cur_epsilon - 16'd1;
						1: a.explore_draw = cur_epsilon;
						2: a.explore_draw = '0;
						3: a.explore_draw = '1;
						default: a.explore_draw = 16'($urandom());
					endcase
				end else begin
					a.explore_draw = 16'($urandom());
				end
				if ($urandom_range(0, 1))
					a.query_action = 6'($urandom_range(0, len - 1));
				else
					a.query_action = 6'($urandom_range(0, 63));
				send_action(a);
			end
			sent += len;
		end
	endtask

	// receiver stalls in bursts
	always @(negedge clk) begin
		if (rx_stall == 0 && gaps_on && $urandom_range(0, 9) == 0)
			rx_stall = $urandom_range(1, 11);
		if (rx_stall != 0) begin
			m_axis_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_decisions
		decision_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (decisions_due.size() == 0) begin
				$error("decision beat with nothing pending: tdata 0x%h tuser %b",
					m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = decisions_due.pop_front();
				check_field("chosen_action", 32'(want.chosen), 32'(m_axis_tdata[5:0]));
				check_field("explored", 32'(want.explored), 32'(m_axis_tdata[6]));
				check_field("query_prob", 32'(want.prob), 32'(m_axis_tdata[23:7]));
				check_field("no_choice", 32'(want.no_choice), 32'(m_axis_tuser));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		open_new_set();
		cur_epsilon = EPSILON_RST;
		cur_margin  = TIE_MARGIN_RST;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_tie_tracking();
		test_zero_margin();
		test_epsilon_extremes();

		test_random_sets(EPSILON_RST, TIE_MARGIN_RST, ITEMS_PER_PHASE);
		test_random_sets(16'd0, 17'd1, ITEMS_PER_PHASE);
		test_random_sets(16'hFFFF, 17'h10000, ITEMS_PER_PHASE);
		test_random_sets(16'($urandom()), 17'd0, ITEMS_PER_PHASE);
		test_random_sets(16'($urandom()), 17'($urandom_range(1, 16)), ITEMS_PER_PHASE);
		test_random_sets(16'($urandom()), 17'($urandom_range(1, 65536)), ITEMS_PER_PHASE);
		test_random_sets(16'd32768, 17'h10000, ITEMS_PER_PHASE);
		gaps_on = 1'b0;
		test_random_sets(16'($urandom()), 17'($urandom_range(1, 4096)), ITEMS_PER_PHASE);
		drain();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
